### hdl/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg: shared types and constants of the timed message queue
// Request and status codes, the stored entry layout, compare unit results
// and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

  localparam int DefQueueDepth = 16;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_QRY  = 2'd1,
    REQ_REM  = 2'd2,
    REQ_POLL = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2,
    STAT_NULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic signed [63:0] due_time;
    logic [7:0]         handler_id;
    logic signed [31:0] message_code;
    logic [15:0]        object_id;
  } entry_t;

  typedef struct packed {
    req_type_e          req_type;
    logic signed [63:0] due_time;
    logic [7:0]         handler_id;
    logic signed [31:0] message_code;
    logic [15:0]        object_id;
  } req_t;

  typedef struct packed {
    logic le;     // entry time at or below request time
    logic match;  // handler, code and (unless zero) object agree
  } cmp_t;

  typedef struct packed {
    status_e     status;
    entry_t      pop;
    logic [4:0]  occupancy;
  } rsp_t;

endpackage

`default_nettype wire

### hdl/tmq_req_if.sv
// ----------------------------------------------------------------------------
// tmq_req_if: request channel of the timed message queue
// Valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [63:0] due_time;
  logic [7:0]         handler_id;
  logic signed [31:0] message_code;
  logic [15:0]        object_id;

  modport source (
    output valid, req_type, due_time, handler_id, message_code, object_id,
    input  ready
  );

  modport sink (
    input  valid, req_type, due_time, handler_id, message_code, object_id,
    output ready
  );
endinterface

`default_nettype wire

### hdl/tmq_rsp_if.sv
// ----------------------------------------------------------------------------
// tmq_rsp_if: response channel of the timed message queue
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] out_time;
  logic [7:0]         out_handler;
  logic signed [31:0] out_code;
  logic [15:0]        out_object;
  logic [4:0]         occupancy;

  modport source (
    output valid, status, out_time, out_handler, out_code, out_object, occupancy,
    input  ready
  );

  modport sink (
    input  valid, status, out_time, out_handler, out_code, out_object, occupancy,
    output ready
  );
endinterface

`default_nettype wire

### hdl/timed_message_queue.sv
// ----------------------------------------------------------------------------
// timed_message_queue: time-ordered message queue with tag removal
// Entries sorted by signed due time, equal times in arrival order. Enqueue,
// has-query, remove matching and poll head, one result item per request.
//
//   channel   dir   handshake           payload
//   req_i     in    valid/ready         req_type, due_time, handler_id,
//                                       message_code, object_id
//   rsp_o     out   valid/ready         status, out_time, out_handler,
//                                       out_code, out_object, occupancy
//
// The time from accept to result grows with the entries held, as the entry
// memory gives one entry a cycle to the shared compare unit; rejected
// requests skip the scan. Reset clears only the state, the entry count and
// the result valid; the memory needs no clearing pass.
// Only one request is in work at a time; a new item is taken while the last
// result still waits in the output register, and a stalled result holds the
// sequencer in its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_message_queue #(
  parameter int QUEUE_DEPTH = tmq_pkg::DefQueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tmq_req_if.sink     req_i,
  tmq_rsp_if.source   rsp_o
);
  import tmq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   cur_q, cur_d;
  logic [CW-1:0]   wptr_q, wptr_d;
  logic [IW-1:0]   put_q, put_d;
  status_e         stat_q, stat_d;
  entry_t          pop_q, pop_d;
  rsp_t            rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic [IW-1:0]   mem_raddr;
  entry_t          mem_rdata;
  cmp_t            cmp_res;

  logic [CW-1:0]   cur_ext;
  logic [CW-1:0]   cur_inc;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   w_next;
  logic            cur_last;
  logic            drop;
  logic [CW+4:0]   occ_ext;

  tmq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IW          (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Every scan step holds the entry read last cycle against the request.
  tmq_cmp u_cmp (
    .entry_i (mem_rdata),
    .req_i   (req_q),
    .res_o   (cmp_res)
  );

  assign cur_ext  = CW'(cur_q);
  assign cur_inc  = cur_ext + CW'(1);
  assign cnt_m1   = cnt_q - CW'(1);
  assign cur_last = (cur_inc == cnt_q);
  // Poll compacts like remove, dropping only the head.
  assign drop     = (req_q.req_type == REQ_REM) ? cmp_res.match : (cur_q == '0);
  assign w_next   = drop ? wptr_q : (wptr_q + CW'(1));
  assign occ_ext  = {5'd0, cnt_q};

  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.out_time    = rsp_q.pop.due_time;
  assign rsp_o.out_handler = rsp_q.pop.handler_id;
  assign rsp_o.out_code    = rsp_q.pop.message_code;
  assign rsp_o.out_object  = rsp_q.pop.object_id;
  assign rsp_o.occupancy   = rsp_q.occupancy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    cur_q  <= cur_d;
    wptr_q <= wptr_d;
    put_q  <= put_d;
    stat_q <= stat_d;
    pop_q  <= pop_d;
    rsp_q  <= rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    wptr_d      = wptr_q;
    put_d       = put_q;
    stat_d      = stat_q;
    pop_d       = pop_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;

    mem_we    = 1'b0;
    mem_waddr = cur_inc[IW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d.req_type     = req_type_e'(req_i.req_type);
          req_d.due_time     = req_i.due_time;
          req_d.handler_id   = req_i.handler_id;
          req_d.message_code = req_i.message_code;
          req_d.object_id    = req_i.object_id;
          pop_d              = '0;
          cur_d              = '0;
          wptr_d             = '0;
          mem_raddr          = '0;
          unique case (req_type_e'(req_i.req_type))
            REQ_ENQ: begin
              if (cnt_q == CW'(QUEUE_DEPTH)) begin
                stat_d  = STAT_FULL;
                state_d = S_FIN;
              end else if (cnt_q == '0) begin
                put_d   = '0;
                state_d = S_PUT;
              end else begin
                // Scan from the tail, shifting later entries up by one.
                mem_raddr = cnt_m1[IW-1:0];
                cur_d     = cnt_m1[IW-1:0];
                state_d   = S_SCAN;
              end
            end
            REQ_QRY, REQ_REM: begin
              if (req_i.handler_id == 8'd0) begin
                stat_d  = STAT_NULL;
                state_d = S_FIN;
              end else if (cnt_q == '0) begin
                stat_d  = STAT_NONE;
                state_d = S_FIN;
              end else begin
                state_d = S_SCAN;
              end
            end
            REQ_POLL: begin
              if (cnt_q == '0) begin
                stat_d  = STAT_NONE;
                state_d = S_FIN;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        case (req_q.req_type)
          REQ_ENQ: begin
            if (cmp_res.le) begin
              put_d   = cur_inc[IW-1:0];
              state_d = S_PUT;
            end else begin
              mem_we = 1'b1;
              if (cur_q == '0) begin
                put_d   = '0;
                state_d = S_PUT;
              end else begin
                mem_raddr = cur_q - IW'(1);
                cur_d     = cur_q - IW'(1);
              end
            end
          end
          REQ_QRY: begin
            if (cmp_res.match) begin
              stat_d  = STAT_OK;
              state_d = S_FIN;
            end else if (cur_last) begin
              stat_d  = STAT_NONE;
              state_d = S_FIN;
            end else begin
              mem_raddr = cur_inc[IW-1:0];
              cur_d     = cur_inc[IW-1:0];
            end
          end
          default: begin
            // Remove and poll: keep survivors, packed down at the write pointer.
            if (drop && (req_q.req_type == REQ_POLL)) begin
              pop_d = mem_rdata;
            end
            if (!drop) begin
              mem_we    = 1'b1;
              mem_waddr = wptr_q[IW-1:0];
            end
            wptr_d = w_next;
            if (cur_last) begin
              cnt_d   = w_next;
              stat_d  = (w_next != cnt_q) ? STAT_OK : STAT_NONE;
              state_d = S_FIN;
            end else begin
              mem_raddr = cur_inc[IW-1:0];
              cur_d     = cur_inc[IW-1:0];
            end
          end
        endcase
      end

      S_PUT: begin
        mem_we                 = 1'b1;
        mem_waddr              = put_q;
        mem_wdata.due_time     = req_q.due_time;
        mem_wdata.handler_id   = req_q.handler_id;
        mem_wdata.message_code = req_q.message_code;
        mem_wdata.object_id    = req_q.object_id;
        cnt_d                  = cnt_q + CW'(1);
        stat_d                 = STAT_OK;
        state_d                = S_FIN;
      end

      S_FIN: begin
        // Hold until the output register is free.
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d     = 1'b1;
          rsp_d.status    = stat_q;
          rsp_d.pop       = pop_q;
          rsp_d.occupancy = occ_ext[4:0];
          state_d         = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/tmq_mem.sv
// ----------------------------------------------------------------------------
// tmq_mem: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_mem #(
  parameter int QUEUE_DEPTH = tmq_pkg::DefQueueDepth,
  parameter int IW          = $clog2(QUEUE_DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IW-1:0]   waddr_i,
  input  wire tmq_pkg::entry_t wdata_i,
  input  wire logic [IW-1:0]   raddr_i,
  output tmq_pkg::entry_t      rdata_o
);
  import tmq_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/tmq_cmp.sv
// ----------------------------------------------------------------------------
// tmq_cmp: shared compare unit
// Signed time order and match test of one stored entry against the request.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_cmp (
  input  wire tmq_pkg::entry_t entry_i,
  input  wire tmq_pkg::req_t   req_i,
  output tmq_pkg::cmp_t        res_o
);
  import tmq_pkg::*;

  always_comb begin
    res_o.le    = ($signed(entry_i.due_time) <= $signed(req_i.due_time));
    res_o.match = (entry_i.handler_id == req_i.handler_id) &&
                  (entry_i.message_code == req_i.message_code) &&
                  ((req_i.object_id == 16'd0) || (entry_i.object_id == req_i.object_id));
  end

endmodule

`default_nettype wire

### hdl/tmq_checker.sv
// ----------------------------------------------------------------------------
// tmq_checker: port-level assertions of the timed message queue
// Watches the request and response channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_checker #(
  parameter int QUEUE_DEPTH = tmq_pkg::DefQueueDepth
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [1:0]  status_i,
  input wire logic [63:0] out_time_i,
  input wire logic [7:0]  out_handler_i,
  input wire logic [31:0] out_code_i,
  input wire logic [15:0] out_object_i,
  input wire logic [4:0]  occupancy_i
);
  import tmq_pkg::*;

  localparam logic [4:0] DepthLow = 5'(QUEUE_DEPTH);

  // A stalled result holds valid, its status, its time and its occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(out_time_i) && $stable(occupancy_i))
    else $error("stalled result changed");

  // A full rejection reports a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STAT_FULL) |-> occupancy_i == DepthLow)
    else $error("full status without full occupancy");

  // Only a successful request can carry popped data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != STAT_OK) |->
      (out_time_i == 64'd0) && (out_handler_i == 8'd0) &&
      (out_code_i == 32'd0) && (out_object_i == 16'd0))
    else $error("popped data on failed request");

  // Accepting a request takes the sequencer busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready after accept");

endmodule

bind timed_message_queue tmq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tmq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .out_time_i    (rsp_o.out_time),
  .out_handler_i (rsp_o.out_handler),
  .out_code_i    (rsp_o.out_code),
  .out_object_i  (rsp_o.out_object),
  .occupancy_i   (rsp_o.occupancy)
);

`default_nettype wire
